// ----- rtl/core/pnpe_pkg.sv -----
// Shared constants, types and codes of the gradient noise point evaluator.
`timescale 1ns / 1ps
package pnpe_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TAB_W      = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 48;
  localparam int OFF_W      = 24;
  localparam int AMP_W      = 32;
  localparam int HASH_W     = 4;
  localparam int CORNERS    = 8;
  localparam int SUMLO_W    = FRAC_BITS + TAB_W;
  localparam int FADE_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 2;

  // Input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;

  typedef logic [TAB_W-1:0]  tab_addr_t;
  typedef logic [TAB_W-1:0]  tab_data_t;
  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FADE_W-1:0] fade_t;

  // Permutation table write request
  typedef struct packed {
    logic      we;
    tab_addr_t addr;
    tab_data_t data;
  } tbl_wr_t;

endpackage

// ----- rtl/core/pnpe_fade.sv -----
// Quintic fade pipeline: 6t^5 - 15t^4 + 10t^3 in four registered steps.
`timescale 1ns / 1ps
module pnpe_fade import pnpe_pkg::*; (
  input  logic  clk,
  input  frac_t t,
  output fade_t f
);

  localparam int F  = FRAC_BITS;
  localparam int LW = F + 6;
  localparam int MW = 2 * F + 6;
  localparam int WW = F + 5;
  localparam logic signed [LW-1:0] SIX     = LW'(6);
  localparam logic signed [LW-1:0] FIFTEEN = LW'(15) <<< F;
  localparam logic signed [WW-1:0] TEN     = WW'(10) <<< F;

  logic signed [LW-1:0] lin;
  logic signed [MW-1:0] t_s, lin_s;
  logic signed [MW-1:0] m1_r;
  logic [2*F-1:0]       m2_r, m3_r;
  logic [F-1:0]         t_d1_r;
  logic signed [WW-1:0] w_r;
  logic [2*F+3:0]       m4_r;
  fade_t                f_r;

  assign lin   = $signed({6'd0, t}) * SIX - FIFTEEN;
  assign t_s   = $signed(MW'(t));
  assign lin_s = MW'(lin);

  // Step one: t*(6t-15) and t^2
  always_ff @(posedge clk) begin
    m1_r   <= t_s * lin_s;
    m2_r   <= t * t;
    t_d1_r <= t;
  end

  // Step two: w = t*(6t-15)+10 and t^3
  always_ff @(posedge clk) begin
    w_r  <= WW'(m1_r >>> F) + TEN;
    m3_r <= m2_r[2*F-1:F] * t_d1_r;
  end

  // Step three: t^3 * w, w is always positive
  always_ff @(posedge clk) begin
    m4_r <= (2*F+4)'(m3_r[2*F-1:F]) * (2*F+4)'(w_r[WW-2:0]);
  end

  // Step four: scale back
  always_ff @(posedge clk) begin
    f_r <= m4_r[2*F:F];
  end

  assign f = f_r;

endmodule

// ----- rtl/core/pnpe_hash_walk.sv -----
// Permutation table memory and the three-level hash walk over its two read ports.
`timescale 1ns / 1ps
module pnpe_hash_walk import pnpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_wr_t   tbl_wr,
  input  logic      start,
  input  tab_addr_t cx,
  input  tab_addr_t cy,
  input  tab_addr_t cz,
  output logic      done,
  output hash_t     hash [CORNERS]
);

  typedef enum logic [7:0] {
    H_IDLE = 8'b0000_0001,
    H_L1   = 8'b0000_0010,
    H_L2A  = 8'b0000_0100,
    H_L2B  = 8'b0000_1000,
    H_L3A  = 8'b0001_0000,
    H_L3B  = 8'b0010_0000,
    H_L3C  = 8'b0100_0000,
    H_L3D  = 8'b1000_0000
  } walk_state_t;

  walk_state_t state_r, state_nxt;

  tab_data_t mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] tvld_r;
  tab_data_t q_a_r, q_b_r;
  logic      v_a_r, v_b_r;
  tab_data_t rd_a, rd_b;
  tab_addr_t addr_a, addr_b;

  tab_addr_t b_r, aa_r, ab_r, ba_r, bb_r;
  tab_addr_t b_nxt, aa_nxt, ab_nxt, ba_nxt, bb_nxt;
  hash_t     hash_r [CORNERS];

  // Table write port; entries never written read as zero
  always_ff @(posedge clk) begin
    if (tbl_wr.we) begin
      mem[tbl_wr.addr] <= tbl_wr.data;
    end
    q_a_r <= mem[addr_a];
    q_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r <= '0;
      v_a_r  <= 1'b0;
      v_b_r  <= 1'b0;
    end else begin
      if (tbl_wr.we) begin
        tvld_r[tbl_wr.addr] <= 1'b1;
      end
      v_a_r <= tvld_r[addr_a];
      v_b_r <= tvld_r[addr_b];
    end
  end

  assign rd_a = v_a_r ? q_a_r : '0;
  assign rd_b = v_b_r ? q_b_r : '0;

  // Walk sequencer: issue two reads a cycle, consume the previous pair
  always_comb begin
    state_nxt = state_r;
    addr_a    = cx;
    addr_b    = cx + 1'b1;
    b_nxt     = b_r;
    aa_nxt    = aa_r;
    ab_nxt    = ab_r;
    ba_nxt    = ba_r;
    bb_nxt    = bb_r;
    case (state_r)
      H_IDLE: begin
        if (start) begin
          state_nxt = H_L1;
        end
      end
      H_L1: begin
        addr_a    = rd_a + cy;
        addr_b    = rd_a + cy + 1'b1;
        b_nxt     = rd_b + cy;
        state_nxt = H_L2A;
      end
      H_L2A: begin
        aa_nxt    = rd_a + cz;
        ab_nxt    = rd_b + cz;
        addr_a    = b_r;
        addr_b    = b_r + 1'b1;
        state_nxt = H_L2B;
      end
      H_L2B: begin
        ba_nxt    = rd_a + cz;
        bb_nxt    = rd_b + cz;
        addr_a    = aa_r;
        addr_b    = rd_a + cz;
        state_nxt = H_L3A;
      end
      H_L3A: begin
        addr_a    = ab_r;
        addr_b    = bb_r;
        state_nxt = H_L3B;
      end
      H_L3B: begin
        addr_a    = aa_r + 1'b1;
        addr_b    = ba_r + 1'b1;
        state_nxt = H_L3C;
      end
      H_L3C: begin
        addr_a    = ab_r + 1'b1;
        addr_b    = bb_r + 1'b1;
        state_nxt = H_L3D;
      end
      H_L3D: begin
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold intermediate indexes and capture corner hashes
  always_ff @(posedge clk) begin
    b_r  <= b_nxt;
    aa_r <= aa_nxt;
    ab_r <= ab_nxt;
    ba_r <= ba_nxt;
    bb_r <= bb_nxt;
    if (state_r == H_L3A) begin
      hash_r[0] <= rd_a[HASH_W-1:0];
      hash_r[1] <= rd_b[HASH_W-1:0];
    end
    if (state_r == H_L3B) begin
      hash_r[2] <= rd_a[HASH_W-1:0];
      hash_r[3] <= rd_b[HASH_W-1:0];
    end
    if (state_r == H_L3C) begin
      hash_r[4] <= rd_a[HASH_W-1:0];
      hash_r[5] <= rd_b[HASH_W-1:0];
    end
    if (state_r == H_L3D) begin
      hash_r[6] <= rd_a[HASH_W-1:0];
      hash_r[7] <= rd_b[HASH_W-1:0];
    end
  end

  assign done = (state_r == H_L3D);
  assign hash = hash_r;

endmodule

// ----- rtl/core/pnpe_blend.sv -----
// Gradient dot products, trilinear lerp, amplitude scaling and saturating add.
`timescale 1ns / 1ps
module pnpe_blend import pnpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  hash_t                     hash [CORNERS],
  input  frac_t                     x,
  input  frac_t                     y,
  input  frac_t                     z,
  input  fade_t                     fx,
  input  fade_t                     fy,
  input  fade_t                     fz,
  input  logic [AMP_W-1:0]          amp,
  input  logic signed [COORD_W-1:0] prior,
  output logic                      done,
  output logic signed [COORD_W-1:0] sum
);

  localparam int F      = FRAC_BITS;
  localparam int GRAD_W = F + 2;
  localparam int LW     = F + 4;
  localparam int PW     = 2 * F + 8;
  localparam int AW     = LW + AMP_W + 1;
  localparam int SW     = COORD_W + 1;
  localparam int STAGES = 10;
  localparam logic signed [COORD_W-1:0] MAX_S = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] MIN_S = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic signed [GRAD_W-1:0] grad(
    input hash_t h,
    input logic signed [F:0] dx,
    input logic signed [F:0] dy,
    input logic signed [F:0] dz
  );
    logic signed [GRAD_W-1:0] gx, gy, gz;
    logic signed [GRAD_W-1:0] g;
    gx = GRAD_W'(dx);
    gy = GRAD_W'(dy);
    gz = GRAD_W'(dz);
    case (h & 4'b1011)
      4'd0:    g = gx + gy;
      4'd1:    g = gy - gx;
      4'd2:    g = gx - gy;
      4'd3:    g = -gx - gy;
      4'd8:    g = gy + gz;
      4'd9:    g = gz - gy;
      4'd10:   g = gy - gz;
      4'd11:   g = -gy - gz;
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [PW-1:0] lmul(
    input fade_t f,
    input logic signed [LW-1:0] a,
    input logic signed [LW-1:0] b
  );
    logic signed [PW-1:0] fs, ds;
    fs = $signed(PW'(f));
    ds = PW'(b) - PW'(a);
    return fs * ds;
  endfunction

  function automatic logic signed [LW-1:0] ladd(
    input logic signed [LW-1:0] a,
    input logic signed [PW-1:0] p
  );
    return a + LW'(p >>> F);
  endfunction

  logic [STAGES-1:0]        vld_r;
  logic signed [F:0]        dx0, dx1, dy0, dy1, dz0, dz1;
  logic signed [LW-1:0]     g_r  [CORNERS];
  logic signed [PW-1:0]     px_r [4];
  logic signed [LW-1:0]     ax_r [4];
  logic signed [LW-1:0]     lx_r [4];
  logic signed [PW-1:0]     py_r [2];
  logic signed [LW-1:0]     ay_r [2];
  logic signed [LW-1:0]     ly_r [2];
  logic signed [PW-1:0]     pz_r;
  logic signed [LW-1:0]     az_r;
  logic signed [LW-1:0]     n_r;
  logic signed [AW-1:0]     pa_r;
  logic signed [SW-1:0]     s_wide;
  logic signed [COORD_W-1:0] sum_r;

  // Corner offsets: the far corner is the fraction minus one
  assign dx0 = $signed({1'b0, x});
  assign dx1 = $signed({1'b1, x});
  assign dy0 = $signed({1'b0, y});
  assign dy1 = $signed({1'b1, y});
  assign dz0 = $signed({1'b0, z});
  assign dz1 = $signed({1'b1, z});

  // Advance the stage marker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], start};
    end
  end

  // Dot products, corner index bits select x, y, z side
  always_ff @(posedge clk) begin
    for (int i = 0; i < CORNERS; i++) begin
      g_r[i] <= LW'(grad(hash[i],
                         i[0] ? dx1 : dx0,
                         i[1] ? dy1 : dy0,
                         i[2] ? dz1 : dz0));
    end
  end

  // Lerp along x
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      px_r[k] <= lmul(fx, g_r[2*k], g_r[2*k+1]);
      ax_r[k] <= g_r[2*k];
      lx_r[k] <= ladd(ax_r[k], px_r[k]);
    end
  end

  // Lerp along y, then z
  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      py_r[j] <= lmul(fy, lx_r[2*j], lx_r[2*j+1]);
      ay_r[j] <= lx_r[2*j];
      ly_r[j] <= ladd(ay_r[j], py_r[j]);
    end
    pz_r <= lmul(fz, ly_r[0], ly_r[1]);
    az_r <= ly_r[0];
    n_r  <= ladd(az_r, pz_r);
  end

  // Scale by amplitude, add prior sum and saturate
  assign s_wide = SW'(prior) + SW'(pa_r >>> F);

  always_ff @(posedge clk) begin
    pa_r <= AW'(n_r) * $signed(AW'(amp));
    if (s_wide[SW-1] != s_wide[SW-2]) begin
      sum_r <= s_wide[SW-1] ? MIN_S : MAX_S;
    end else begin
      sum_r <= s_wide[COORD_W-1:0];
    end
  end

  assign done = vld_r[STAGES-1];
  assign sum  = sum_r;

endmodule

// ----- rtl/core/perlin_noise_point_eval_core.sv -----
// Top level of the gradient noise point evaluator.
//
// Use: raise start with the item fields; the item is taken at a rising edge
// where start is high and busy is low. A load item (in_command = 0) writes
// in_table_value into permutation entry in_table_index in that edge and
// leaves busy low, so loads run one per cycle and give no result.
// An evaluate item (in_command = 1) raises busy from the next cycle on.
// The three table levels are read through the two ports of the table memory,
// the fades run alongside, and the blend pipeline follows. out_valid pulses
// for one cycle with out_sum, and busy drops the cycle after, so the next
// item is taken only after the evaluate is through. The receiver cannot
// stall: out_sum is valid in the out_valid cycle only.
// Offsets are written through cfg_we / cfg_index / cfg_wdata, by the user
// only while idle (the block does not enforce it); index three is ignored.
// Reset clears the offsets, the sequencers and the table valid bits, so
// the whole table reads as zero right after reset with no clearing pass.
`timescale 1ns / 1ps
module perlin_noise_point_eval_core import pnpe_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic                      in_two_d,
  input  logic [TAB_W-1:0]          in_table_index,
  input  logic [TAB_W-1:0]          in_table_value,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [AMP_W-1:0]          in_amplitude,
  input  logic signed [COORD_W-1:0] in_prior_sum,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_sum,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [OFF_W-1:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_WALK  = 3'b010,
    T_BLEND = 3'b100
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [OFF_W-1:0] offset_x_r, offset_y_r, offset_z_r;
  logic             accept, accept_eval;
  logic             go_r;
  logic [SUMLO_W-1:0] sx, sy, sz;
  tab_addr_t        cx_r, cy_r, cz_r;
  frac_t            x_r, y_r, z_r;
  logic [AMP_W-1:0] amp_r;
  logic signed [COORD_W-1:0] prior_r;
  tbl_wr_t          tbl_wr;
  logic             walk_done, blend_done;
  hash_t            hash [CORNERS];
  fade_t            fx, fy, fz;

  assign accept      = start && !busy;
  assign accept_eval = accept && (in_command == CMD_EVAL);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_X: offset_x_r <= cfg_wdata;
        CFG_OFFSET_Y: offset_y_r <= cfg_wdata;
        CFG_OFFSET_Z: offset_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Only the low cell and fraction bits of the offset sums matter
  assign sx = in_coord_x[SUMLO_W-1:0] + SUMLO_W'(offset_x_r);
  assign sy = in_coord_y[SUMLO_W-1:0] + SUMLO_W'(offset_y_r);
  assign sz = in_coord_z[SUMLO_W-1:0] + SUMLO_W'(offset_z_r);

  // Capture the point of an evaluate item
  always_ff @(posedge clk) begin
    if (accept_eval) begin
      cx_r    <= sx[SUMLO_W-1:FRAC_BITS];
      x_r     <= sx[FRAC_BITS-1:0];
      cz_r    <= sz[SUMLO_W-1:FRAC_BITS];
      z_r     <= sz[FRAC_BITS-1:0];
      cy_r    <= in_two_d ? '0 : sy[SUMLO_W-1:FRAC_BITS];
      y_r     <= in_two_d ? '0 : sy[FRAC_BITS-1:0];
      amp_r   <= in_amplitude;
      prior_r <= in_prior_sum;
    end
  end

  // Table writes from load items
  assign tbl_wr.we   = accept && (in_command == CMD_LOAD);
  assign tbl_wr.addr = in_table_index;
  assign tbl_wr.data = in_table_value;

  // Item sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      T_IDLE:  if (accept_eval) state_nxt = T_WALK;
      T_WALK:  if (walk_done)   state_nxt = T_BLEND;
      T_BLEND: if (blend_done)  state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= accept_eval;
    end
  end

  assign busy = (state_r != T_IDLE);

  pnpe_hash_walk u_walk (
    .clk    (clk),
    .rst_n  (rst_n),
    .tbl_wr (tbl_wr),
    .start  (go_r),
    .cx     (cx_r),
    .cy     (cy_r),
    .cz     (cz_r),
    .done   (walk_done),
    .hash   (hash)
  );

  pnpe_fade u_fade_x (.clk(clk), .t(x_r), .f(fx));
  pnpe_fade u_fade_y (.clk(clk), .t(y_r), .f(fy));
  pnpe_fade u_fade_z (.clk(clk), .t(z_r), .f(fz));

  pnpe_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .start (walk_done),
    .hash  (hash),
    .x     (x_r),
    .y     (y_r),
    .z     (z_r),
    .fx    (fx),
    .fy    (fy),
    .fz    (fz),
    .amp   (amp_r),
    .prior (prior_r),
    .done  (blend_done),
    .sum   (out_sum)
  );

  assign out_valid = blend_done && (state_r == T_BLEND);

endmodule

// ----- rtl/core/pnpe_checker.sv -----
// Port-level checks of the noise evaluator and their bind to the top level.
`timescale 1ns / 1ps
module pnpe_checker import pnpe_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_command,
  input logic out_valid
);

  // Results come only while an evaluate item is in flight
  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");

  // An accepted evaluate item makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_EVAL) |=> busy)
    else $error("evaluate item did not raise busy");

  // A load item leaves the block free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_LOAD) |=> !busy)
    else $error("load item raised busy");

  // One result per item: the strobe does not repeat back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe repeated");

  // Reset leaves the block idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid)) else $error("not idle after reset");

endmodule

bind perlin_noise_point_eval_core pnpe_checker u_pnpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);
